>>> sv/multi_queue_byte_ring_fifo_core_macros.svh
// assertion helpers for the checker file
`ifndef MULTI_QUEUE_BYTE_RING_FIFO_CORE_MACROS_SVH
`define MULTI_QUEUE_BYTE_RING_FIFO_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MQBRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mqbrf assertion failed");

// next-cycle implication, disabled while reset is low
`define MQBRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mqbrf assertion failed");

`endif

>>> sv/mqbrf_pkg.sv
package mqbrf_pkg;

  localparam int QUEUE_COUNT_DEF = 4;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam int QID_IN_W  = 3;
  localparam int BYTE_W    = 8;

  // opcode values
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } mqbrf_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // pointer compare, memory access, result capture
  } mqbrf_cmd_t;

endpackage

>>> sv/mqbrf_ctrl.sv
module mqbrf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output logic                  out_valid,
  output mqbrf_pkg::mqbrf_cmd_t cmd
);
  import mqbrf_pkg::*;

  mqbrf_state_t state_r;
  mqbrf_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        out_valid = 1'b1;
        cmd.load  = start;
        if (start) begin
          state_nxt = ST_EXEC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/mqbrf_dp.sv
module mqbrf_dp #(
  parameter int QUEUE_COUNT = mqbrf_pkg::QUEUE_COUNT_DEF,
  parameter int QUEUE_DEPTH = mqbrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mqbrf_pkg::mqbrf_cmd_t           cmd,
  input  logic                            in_opcode,
  input  logic [mqbrf_pkg::QID_IN_W-1:0]  in_queue_id,
  input  logic [mqbrf_pkg::BYTE_W-1:0]    in_data_in,
  output logic                            out_ok,
  output logic [mqbrf_pkg::BYTE_W-1:0]    out_data_out,
  output logic                            out_is_empty,
  output logic                            out_is_full
);
  import mqbrf_pkg::*;

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QID_W     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int ADDR_W    = QID_W + PTR_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam logic [PTR_W-1:0]      PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QID_IN_W:0]     QCNT     = (QID_IN_W + 1)'(QUEUE_COUNT);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // captured item
  logic                 op_r;
  logic [QID_IN_W-1:0]  qid_r;
  logic [BYTE_W-1:0]    din_r;

  // per-queue pointers
  logic [PTR_W-1:0] head_r [QUEUE_COUNT];
  logic [PTR_W-1:0] tail_r [QUEUE_COUNT];

  // byte store, one ring per queue
  logic [BYTE_W-1:0] mem [MEM_DEPTH];

  // result registers
  logic              ok_r;
  logic              deq_ok_r;
  logic              empty_r;
  logic              full_r;
  logic [BYTE_W-1:0] rd_r;

  logic             q_valid;
  logic [QID_W-1:0] qsel;
  logic [PTR_W-1:0] head_cur;
  logic [PTR_W-1:0] tail_cur;
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_nxt;
  logic             cur_empty;
  logic             cur_full;
  logic             enq_ok;
  logic             deq_ok;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      qid_r <= in_queue_id;
      din_r <= in_data_in;
    end
  end

  assign q_valid = {1'b0, qid_r} < QCNT;
  assign qsel    = qid_r[QID_W-1:0];

  always_comb begin
    head_cur = '0;
    tail_cur = '0;
    if (q_valid) begin
      head_cur = head_r[qsel];
      tail_cur = tail_r[qsel];
    end
  end

  assign cur_empty = (head_cur == tail_cur);
  assign cur_full  = (ptr_inc(tail_cur) == head_cur);
  assign enq_ok    = q_valid && (op_r == OP_ENQUEUE) && !cur_full;
  assign deq_ok    = q_valid && (op_r == OP_DEQUEUE) && !cur_empty;
  assign head_nxt  = deq_ok ? ptr_inc(head_cur) : head_cur;
  assign tail_nxt  = enq_ok ? ptr_inc(tail_cur) : tail_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (enq_ok) begin
        tail_r[qsel] <= tail_nxt;
      end
      if (deq_ok) begin
        head_r[qsel] <= head_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (enq_ok) begin
        mem[{qsel, tail_cur}] <= din_r;
      end
      rd_r <= mem[{qsel, head_cur}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r     <= enq_ok || deq_ok;
      deq_ok_r <= deq_ok;
      empty_r  <= q_valid && (head_nxt == tail_nxt);
      full_r   <= q_valid && (ptr_inc(tail_nxt) == head_nxt);
    end
  end

  assign out_ok       = ok_r;
  assign out_data_out = deq_ok_r ? rd_r : '0;
  assign out_is_empty = empty_r;
  assign out_is_full  = full_r;

endmodule

>>> sv/multi_queue_byte_ring_fifo_core.sv
// channel   ports                                         handshake
// input     in_opcode, in_queue_id, in_data_in            start high, busy low
// result    out_ok, out_data_out, out_is_empty, out_is_full  out_valid, one cycle
//
// each item is first captured, then gets the pointer compare and byte store access
// the result is strobed on out_valid in the cycle after that, and a new item may be
// accepted in that same cycle; no new item is taken while the block is busy executing
// the byte store has a registered read port
// synchronous reset clears every pointer at once, no clearing pass over the byte store
// the receiver cannot stall, the result stands for exactly one cycle
module multi_queue_byte_ring_fifo_core #(
  parameter int QUEUE_COUNT = mqbrf_pkg::QUEUE_COUNT_DEF,
  parameter int QUEUE_DEPTH = mqbrf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command side
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [mqbrf_pkg::QID_IN_W-1:0]  in_queue_id,
  input  logic [mqbrf_pkg::BYTE_W-1:0]    in_data_in,
  // result side
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [mqbrf_pkg::BYTE_W-1:0]    out_data_out,
  output logic                            out_is_empty,
  output logic                            out_is_full
);
  import mqbrf_pkg::*;

  // load and execute commands from the sequencer
  mqbrf_cmd_t cmd;

  // sequencer: idle, execute, present result
  mqbrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // pointers, flag compare, byte store and result registers
  mqbrf_dp #(
    .QUEUE_COUNT (QUEUE_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_opcode    (in_opcode),
    .in_queue_id  (in_queue_id),
    .in_data_in   (in_data_in),
    .out_ok       (out_ok),
    .out_data_out (out_data_out),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full)
  );

endmodule

>>> sv/mqbrf_checker.sv
`include "multi_queue_byte_ring_fifo_core_macros.svh"

module mqbrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_ok,
  input logic [7:0] out_data_out,
  input logic       out_is_empty,
  input logic       out_is_full
);

  // execution lasts a single cycle
  `MQBRF_ASSERT_NXT(a_busy_one_cycle, clk, rst_n, busy, !busy)
  // busy only after an accepted transfer
  `MQBRF_ASSERT_IMP(a_busy_from_accept, clk, rst_n, busy, $past(start && !busy))
  // every result follows an execute cycle
  `MQBRF_ASSERT_IMP(a_result_after_exec, clk, rst_n, out_valid, $past(busy))
  // failed operations return a zero byte
  `MQBRF_ASSERT_IMP(a_fail_zero_data, clk, rst_n, out_valid && !out_ok, out_data_out == 8'd0)
  // a queue is never both empty and full
  `MQBRF_ASSERT_IMP(a_flags_exclusive, clk, rst_n, out_valid, !(out_is_empty && out_is_full))

endmodule

bind multi_queue_byte_ring_fifo_core mqbrf_checker u_mqbrf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_ok       (out_ok),
  .out_data_out (out_data_out),
  .out_is_empty (out_is_empty),
  .out_is_full  (out_is_full)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import mqbrf_pkg::*;

  localparam int QCOUNT = QUEUE_COUNT_DEF;
  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  // generous ceiling on the whole run
  localparam int RUN_LIMIT_NS = 5_000_000;
  // cycles allowed for the last results to drain
  localparam int DRAIN_LIMIT = 1000;
  // room for a late or stray result once the expectations are gone
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_REPORTS = 10;

  // one result as the block presents it
  typedef struct packed {
    logic              ok;
    logic [BYTE_W-1:0] data;
    logic              empty;
    logic              full;
  } queue_result_t;

  // ring bank predictor plus the store of results still owed by the block
  class ring_bank_scoreboard;
    int unsigned       head_ptr [QCOUNT];
    int unsigned       tail_ptr [QCOUNT];
    logic [BYTE_W-1:0] ring_bytes [QCOUNT][QDEPTH];
    queue_result_t     owed [$];
    int                mismatches;

    function void clear_pointers();
      foreach (head_ptr[i]) begin
        head_ptr[i] = 0;
        tail_ptr[i] = 0;
      end
      owed.delete();
      mismatches = 0;
    endfunction

    function bit ring_empty(int unsigned q);
      return head_ptr[q] == tail_ptr[q];
    endfunction

    function bit ring_full(int unsigned q);
      return ((tail_ptr[q] + 1) % QDEPTH) == head_ptr[q];
    endfunction

    // apply one accepted operation and queue up the result it must produce
    function void note_transfer(logic op, logic [QID_IN_W-1:0] q, logic [BYTE_W-1:0] d);
      queue_result_t r;
      r = '0;
      if (q < QCOUNT) begin
        if (op == OP_ENQUEUE) begin
          if (!ring_full(q)) begin
            ring_bytes[q][tail_ptr[q]] = d;
            tail_ptr[q] = (tail_ptr[q] + 1) % QDEPTH;
            r.ok = 1'b1;
          end
        end else begin
          if (!ring_empty(q)) begin
            r.data = ring_bytes[q][head_ptr[q]];
            head_ptr[q] = (head_ptr[q] + 1) % QDEPTH;
            r.ok = 1'b1;
          end
        end
        r.empty = ring_empty(q);
        r.full  = ring_full(q);
      end
      owed.push_back(r);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result ok=%0b data=%02h empty=%0b full=%0b",
                   got.ok, got.data, got.empty, got.full);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected ok=%0b data=%02h empty=%0b full=%0b,",
                   want.ok, want.data, want.empty, want.full,
                   " got ok=%0b data=%02h empty=%0b full=%0b",
                   got.ok, got.data, got.empty, got.full);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_opcode;
  logic [QID_IN_W-1:0] in_queue_id;
  logic [BYTE_W-1:0]   in_data_in;
  logic                out_valid;
  logic                out_ok;
  logic [BYTE_W-1:0]   out_data_out;
  logic                out_is_empty;
  logic                out_is_full;

  ring_bank_scoreboard ring_sb;
  // when clear, the sender runs back to back
  bit                  pacing_on;

  multi_queue_byte_ring_fifo_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_opcode    (in_opcode),
    .in_queue_id  (in_queue_id),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ok       (out_ok),
    .out_data_out (out_data_out),
    .out_is_empty (out_is_empty),
    .out_is_full  (out_is_full)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!pacing_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // present one operation and hold it until the block takes the transfer;
  // start stays high afterwards unless a gap is drawn, so a following item can go back to back
  task automatic issue_op(logic op, logic [QID_IN_W-1:0] q, logic [BYTE_W-1:0] d);
    int gap;
    @(negedge clk);
    start       <= 1'b1;
    in_opcode   <= op;
    in_queue_id <= q;
    in_data_in  <= d;
    do @(posedge clk); while (busy);
    ring_sb.note_transfer(op, q, d);
    gap = pick_gap();
    // idle cycles: start low on each falling edge of the gap
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function automatic logic [QID_IN_W-1:0] pick_queue();
    // mostly real queues, now and then any id including the bad ones
    if ($urandom_range(0, 99) < 15)
      return QID_IN_W'($urandom_range(0, (1 << QID_IN_W) - 1));
    return QID_IN_W'($urandom_range(0, QCOUNT - 1));
  endfunction

  // random mix of operations, a bit heavier on enqueue so queues build up
  task automatic random_mix(int count);
    logic op;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) pacing_on = ($urandom_range(0, 3) != 0);
      op = ($urandom_range(0, 99) < 55) ? OP_ENQUEUE : OP_DEQUEUE;
      issue_op(op, pick_queue(), BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // result side: the receiver never stalls, every strobe is a transfer
  always @(posedge clk) begin
    queue_result_t seen;
    if (rst_n && out_valid) begin
      seen.ok    = out_ok;
      seen.data  = out_data_out;
      seen.empty = out_is_empty;
      seen.full  = out_is_full;
      ring_sb.check_result(seen);
    end
  end

  // hard stop if the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL multi_queue_byte_ring_fifo_core");
    $finish;
  end

  initial begin
    int unsigned fill_q;
    int          guard;
    int          leftover;
    ring_sb = new;
    ring_sb.clear_pointers();
    pacing_on   = 1'b1;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_opcode   = OP_ENQUEUE;
    in_queue_id = '0;
    in_data_in  = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: underflow on a fresh queue
    issue_op(OP_DEQUEUE, '0, 8'hFF);
    // byte extremes through queue 0, checking order and the empty flag
    issue_op(OP_ENQUEUE, '0, 8'h00);
    issue_op(OP_ENQUEUE, '0, 8'hFF);
    issue_op(OP_ENQUEUE, QID_IN_W'(QCOUNT - 1), 8'hA5);
    issue_op(OP_DEQUEUE, '0, 8'h00);
    issue_op(OP_DEQUEUE, '0, 8'h00);
    issue_op(OP_DEQUEUE, '0, 8'h5A);
    // out of range ids, both operations, no state change expected
    for (int q = QCOUNT; q < (1 << QID_IN_W); q++) begin
      issue_op(OP_ENQUEUE, QID_IN_W'(q), 8'hFF);
      issue_op(OP_DEQUEUE, QID_IN_W'(q), 8'h00);
    end
    // the middle queues, then drain the last one
    issue_op(OP_ENQUEUE, QID_IN_W'(1 % QCOUNT), 8'h5A);
    issue_op(OP_ENQUEUE, QID_IN_W'(2 % QCOUNT), 8'hC3);
    issue_op(OP_DEQUEUE, QID_IN_W'(1 % QCOUNT), 8'h00);
    issue_op(OP_DEQUEUE, QID_IN_W'(2 % QCOUNT), 8'h00);
    issue_op(OP_DEQUEUE, QID_IN_W'(QCOUNT - 1), 8'hFF);
    issue_op(OP_DEQUEUE, QID_IN_W'(QCOUNT - 1), 8'hFF);

    random_mix(200);

    // fill one queue past full, so the full flag and overflow show up,
    // then drain it past empty; pointers wrap on the way
    fill_q = $urandom_range(0, QCOUNT - 1);
    pacing_on = 1'b1;
    for (int i = 0; i < QDEPTH + 2; i++)
      issue_op(OP_ENQUEUE, QID_IN_W'(fill_q), BYTE_W'($urandom_range(0, 255)));
    pacing_on = 1'b0;
    for (int i = 0; i < QDEPTH + 2; i++)
      issue_op(OP_DEQUEUE, QID_IN_W'(fill_q), BYTE_W'($urandom_range(0, 255)));

    random_mix(230);

    @(negedge clk);
    start <= 1'b0;

    // wait out the results still owed, then a few cycles for strays
    guard = 0;
    while (ring_sb.owed.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    leftover = ring_sb.owed.size();
    if (leftover != 0)
      $display("%0d expected results never arrived", leftover);
    if (ring_sb.mismatches == 0 && leftover == 0) begin
      $display("PASS multi_queue_byte_ring_fifo_core");
    end else begin
      $display("FAIL multi_queue_byte_ring_fifo_core");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/mqbrf_pkg.sv
sv/mqbrf_ctrl.sv
sv/mqbrf_dp.sv
sv/multi_queue_byte_ring_fifo_core.sv
sv/mqbrf_checker.sv
test/testbench.sv
